FILE: rtl/core/uart_rx_flow_and_modem_status_top_macros.svh
// Assertion macros for the UART receive flow-control block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef UART_RX_FLOW_AND_MODEM_STATUS_TOP_MACROS_SVH
`define UART_RX_FLOW_AND_MODEM_STATUS_TOP_MACROS_SVH
`ifndef SYNTH
`define URXFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define URXFC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define URXFC_ASSERT(label, prop, msg)
`define URXFC_ASSERT_RST(label, prop, msg)
`endif
`endif

FILE: rtl/core/urxfc_pkg.sv
// Package for the UART receive flow-control block: transfer types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package urxfc_pkg;

  // event kinds carried in the mode field
  localparam logic [1:0] MODE_RX_CHAR = 2'd0;
  localparam logic [1:0] MODE_MSR     = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;
  localparam logic [1:0] MODE_TX_EMPTY = 2'd3;

  // line status bits
  localparam int LSR_DR = 0;
  localparam int LSR_OE = 1;
  localparam int LSR_PE = 2;
  localparam int LSR_FE = 3;
  localparam int LSR_BI = 4;

  // modem status bits
  localparam int MSR_DCTS = 0;
  localparam int MSR_DDSR = 1;
  localparam int MSR_DDCD = 3;
  localparam int MSR_CTS  = 4;
  localparam int MSR_DSR  = 5;
  localparam int MSR_DCD  = 7;

  localparam logic [7:0] XOFF_CHAR        = 8'h13;
  localparam logic [7:0] XON_CHAR         = 8'h11;
  localparam logic [1:0] CTS_BACKOFF_LOAD = 2'd2;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_XONOFF_EN     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODEM_FLOW_EN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUP_ON_DSR    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUP_ON_DCD    = 8'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] status_bits;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        rx_valid;
    logic [7:0]  rx_data;
    logic        tx_allowed;
    logic        kick;
    logic        hangup;
    logic [15:0] frame_errors;
    logic [15:0] overrun_errors;
  } out_item_t;

  // control settings from the register file to the engine
  typedef struct packed {
    logic xonoff_en;
    logic modem_flow_en;
    logic hup_on_dsr;
    logic hup_on_dcd;
    logic cts_force;   // pulse: hardware flow control turned off
  } cfg_t;

endpackage

FILE: rtl/core/urxfc_cfg.sv
// Configuration registers of the UART receive flow-control block.
// Depends on urxfc_pkg.
`timescale 1ns / 1ps
module urxfc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [urxfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urxfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output urxfc_pkg::cfg_t                 cfg
);
  import urxfc_pkg::*;

  logic xonoff_en_r;
  logic modem_flow_en_r;
  logic hup_on_dsr_r;
  logic hup_on_dcd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xonoff_en_r     <= 1'b0;
      modem_flow_en_r <= 1'b0;
      hup_on_dsr_r    <= 1'b0;
      hup_on_dcd_r    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_XONOFF_EN:     xonoff_en_r     <= cfg_wdata[0];
        REG_MODEM_FLOW_EN: modem_flow_en_r <= cfg_wdata[0];
        REG_HUP_ON_DSR:    hup_on_dsr_r    <= cfg_wdata[0];
        REG_HUP_ON_DCD:    hup_on_dcd_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.xonoff_en     = xonoff_en_r;
    cfg.modem_flow_en = modem_flow_en_r;
    cfg.hup_on_dsr    = hup_on_dsr_r;
    cfg.hup_on_dcd    = hup_on_dcd_r;
    cfg.cts_force     = cfg_valid && (cfg_index == REG_MODEM_FLOW_EN) && !cfg_wdata[0];
  end

endmodule

FILE: rtl/core/urxfc_engine.sv
// Flow-control and modem-status state with its per-event update logic.
// Depends on urxfc_pkg.
`timescale 1ns / 1ps
module urxfc_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_fire,
  input  urxfc_pkg::in_item_t  item,
  input  urxfc_pkg::cfg_t      cfg,
  output urxfc_pkg::out_item_t result
);
  import urxfc_pkg::*;

  logic        tx_blocked_r, tx_blocked_nxt;
  logic        cts_seen_r, cts_seen_nxt;
  logic        dsr_seen_r, dsr_seen_nxt;
  logic        dcd_seen_r, dcd_seen_nxt;
  logic [1:0]  cts_backoff_r, cts_backoff_nxt;
  logic        hup_pend_r, hup_pend_nxt;
  logic [15:0] frame_cnt_r, frame_cnt_nxt;
  logic [15:0] ovr_cnt_r, ovr_cnt_nxt;

  logic [7:0] st;
  logic       rx_ok;
  logic       kick_req;
  logic       hup;
  logic       can_send;

  assign st = item.status_bits;

  always_comb begin
    tx_blocked_nxt  = tx_blocked_r;
    cts_seen_nxt    = cts_seen_r;
    dsr_seen_nxt    = dsr_seen_r;
    dcd_seen_nxt    = dcd_seen_r;
    cts_backoff_nxt = cts_backoff_r;
    hup_pend_nxt    = hup_pend_r;
    frame_cnt_nxt   = frame_cnt_r;
    ovr_cnt_nxt     = ovr_cnt_r;
    rx_ok    = 1'b0;
    kick_req = 1'b0;
    hup      = 1'b0;
    case (item.mode)
      MODE_RX_CHAR: begin
        if (st[LSR_DR]) begin
          if (st[LSR_FE] && (frame_cnt_r != 16'hFFFF)) frame_cnt_nxt = frame_cnt_r + 16'd1;
          if (st[LSR_OE] && (ovr_cnt_r != 16'hFFFF))   ovr_cnt_nxt   = ovr_cnt_r + 16'd1;
          if (!(st[LSR_PE] || st[LSR_FE] || st[LSR_BI])) begin
            rx_ok = 1'b1;
            if (cfg.xonoff_en) begin
              if (item.rx_byte == XOFF_CHAR)     tx_blocked_nxt = 1'b1;
              else if (item.rx_byte == XON_CHAR) tx_blocked_nxt = 1'b0;
            end
          end
        end
      end
      MODE_MSR: begin
        if (st[MSR_DCTS]) begin
          if (!cts_seen_r && st[MSR_CTS]) cts_backoff_nxt = CTS_BACKOFF_LOAD;
          cts_seen_nxt = st[MSR_CTS];
        end
        if (st[MSR_DDSR]) begin
          if (cfg.hup_on_dsr && dsr_seen_r && !st[MSR_DSR]) hup_pend_nxt = 1'b1;
          dsr_seen_nxt = st[MSR_DSR];
        end
        if (st[MSR_DDCD]) begin
          if (cfg.hup_on_dcd && dcd_seen_r && !st[MSR_DCD]) hup_pend_nxt = 1'b1;
          dcd_seen_nxt = st[MSR_DCD];
        end
      end
      MODE_TICK: begin
        if (hup_pend_r) begin
          hup          = 1'b1;
          hup_pend_nxt = 1'b0;
        end
        if (cts_backoff_r != 2'd0) begin
          cts_backoff_nxt = cts_backoff_r - 2'd1;
          kick_req        = (cts_backoff_r == 2'd1);
        end
      end
      MODE_TX_EMPTY: kick_req = 1'b1;
      default: ;
    endcase
    can_send = !tx_blocked_nxt && !(cfg.modem_flow_en && !cts_seen_nxt);
  end

  always_comb begin
    result.rx_valid       = rx_ok;
    result.rx_data        = rx_ok ? item.rx_byte : 8'd0;
    result.tx_allowed     = can_send;
    result.kick           = kick_req && can_send;
    result.hangup         = hup;
    result.frame_errors   = frame_cnt_nxt;
    result.overrun_errors = ovr_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_blocked_r  <= 1'b0;
      cts_seen_r    <= 1'b1;
      dsr_seen_r    <= 1'b0;
      dcd_seen_r    <= 1'b0;
      cts_backoff_r <= 2'd0;
      hup_pend_r    <= 1'b0;
      frame_cnt_r   <= 16'd0;
      ovr_cnt_r     <= 16'd0;
    end else begin
      // config writes must arrive only while idle; the block does not enforce this, and the force wins over an update
      if (cfg.cts_force)    cts_seen_r <= 1'b1;
      else if (item_fire)   cts_seen_r <= cts_seen_nxt;
      if (item_fire) begin
        tx_blocked_r  <= tx_blocked_nxt;
        dsr_seen_r    <= dsr_seen_nxt;
        dcd_seen_r    <= dcd_seen_nxt;
        cts_backoff_r <= cts_backoff_nxt;
        hup_pend_r    <= hup_pend_nxt;
        frame_cnt_r   <= frame_cnt_nxt;
        ovr_cnt_r     <= ovr_cnt_nxt;
      end
    end
  end

endmodule

FILE: rtl/core/uart_rx_flow_and_modem_status_top.sv
// Top level of the UART receive flow-control block: input and result registers.
// Depends on urxfc_pkg, urxfc_cfg, urxfc_engine and the assertion macro header.
`timescale 1ns / 1ps
`include "uart_rx_flow_and_modem_status_top_macros.svh"
// Takes one event per cycle (received character, modem-status change, tick or
// transmitter empty) and returns exactly one result per event, in order. An
// event is registered on acceptance, processed in one pass against the flow
// control state, and its result sits in the output register, which it reaches
// from the input register once the output is free; one event per cycle is sustained
// as long as results are taken. The input register and the result register form the
// pipeline, so a stall on the result side backs up through in_ready.
// Register writes (cfg_ready is always high) are expected only while
// no event is in flight; a modem_flow_enable write of 0 restores the CTS state.
module uart_rx_flow_and_modem_status_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  urxfc_pkg::in_item_t             in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output urxfc_pkg::out_item_t            out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [urxfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urxfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import urxfc_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  cfg_t      cfg;
  logic      out_free;
  logic      s1_move;

  assign out_free  = !out_valid_r || out_ready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || s1_move;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  urxfc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  urxfc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (s1_move),
    .item      (s1_item_r),
    .cfg       (cfg),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready)  s1_valid_r  <= in_valid;
      if (out_free)  out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item_r  <= in_item;
    if (s1_move)              out_item_r <= result;
  end

  `URXFC_ASSERT(a_accept_fills_stage, in_valid && in_ready |=> s1_valid_r, "accepted transfer lost before processing")
  `URXFC_ASSERT(a_kick_needs_tx, out_valid_r |-> (!out_item_r.kick || out_item_r.tx_allowed), "kick while transmission not allowed")
  `URXFC_ASSERT(a_data_zero_idle, out_valid_r |-> (out_item_r.rx_valid || out_item_r.rx_data == 8'd0), "data set without valid character")
  `URXFC_ASSERT(a_stall_holds, out_valid_r && !out_ready |=> s1_valid_r == $past(s1_valid_r) || $past(!s1_valid_r), "pipeline advanced into a stalled result")

endmodule
